### rtl/core/dtbp_pkg.sv
// ----------------------------------------------------------------------------
// dtbp_pkg
// Types, codes, coefficient tables and the microcode table shared by the
// dual-tone bandpass peak detector.
// ----------------------------------------------------------------------------
package dtbp_pkg;

  // real coefficients in units of 1e-8, [filter][row]
  localparam longint RealScale = 100000000;

  localparam longint REAL_G [2][4] = '{
    '{201900, 196400, 2280000, 2294000},
    '{303500, 295500, 2263000, 2271000}
  };
  localparam longint REAL_A1 [2][4] = '{
    '{-184602348, -184997046, -185002393, -185937390},
    '{-177495574, -178072480, -177882789, -179257281}
  };
  localparam longint REAL_A2 [2][4] = '{
    '{98747166, 98763379, 99474384, 99490711},
    '{98471132, 98490396, 99358215, 99377646}
  };

  typedef logic [1:0][3:0][31:0] coef_tbl_t;

  typedef enum logic [1:0] {
    COEF_G,
    COEF_A1,
    COEF_A2
  } coef_kind_t;

  // fixed-point table, truncated toward zero, evaluated at elaboration
  function automatic coef_tbl_t coef_table(input coef_kind_t kind, input int shift);
    coef_tbl_t t;
    longint    r;
    t = '0;
    for (int f = 0; f < 2; f++) begin
      for (int row = 0; row < 4; row++) begin
        case (kind)
          COEF_A1: r = REAL_A1[f][row];
          COEF_A2: r = REAL_A2[f][row];
          default: r = REAL_G[f][row];
        endcase
        t[f][row] = 32'((r * (longint'(1) <<< shift)) / RealScale);
      end
    end
    return t;
  endfunction

  // channel items
  typedef struct packed {
    logic [11:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] filtered_low;
    logic signed [15:0] filtered_high;
    logic               low_tone_present;
    logic               high_tone_present;
    logic               window_end;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [14:0] data;
  } cfg_item_t;

  localparam logic [1:0] CFG_THRESHOLD_LOW  = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD_HIGH = 2'd1;

  localparam logic [14:0] THRESHOLD_RESET = 15'd250;

  // sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_ADD_B1,
    ACC_ADD_B2,
    ACC_SUB_PROD
  } acc_op_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_A1,
    MUL_A2,
    MUL_G
  } mul_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_SECTION,
    JMP_FILTER
  } jmp_t;

  typedef struct packed {
    acc_op_t acc_op;
    mul_op_t mul_op;
    logic    hist_wr;
    jmp_t    jmp;
  } uc_word_t;

  typedef struct packed {
    acc_op_t acc_op;
    mul_op_t mul_op;
    logic    hist_wr;
    logic    x_load;
  } dp_ctrl_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_LOAD     = 3'd0;
  localparam step_t STEP_ADD_B1   = 3'd1;
  localparam step_t STEP_ADD_B2   = 3'd2;
  localparam step_t STEP_SUB_A1   = 3'd3;
  localparam step_t STEP_SUB_A2   = 3'd4;
  localparam step_t STEP_MUL_G    = 3'd5;
  localparam step_t STEP_WRITE    = 3'd6;
  localparam step_t STEP_FILT_END = 3'd7;

  // one biquad section per pass through steps load..write
  function automatic uc_word_t ucode(input step_t step);
    uc_word_t w;
    w = '{acc_op: ACC_HOLD, mul_op: MUL_NONE, hist_wr: 1'b0, jmp: JMP_NEXT};
    unique case (step)
      STEP_LOAD: begin
        w.acc_op = ACC_LOAD_X;
        w.mul_op = MUL_A1;
      end
      STEP_ADD_B1: w.acc_op = ACC_ADD_B1;
      STEP_ADD_B2: w.acc_op = ACC_ADD_B2;
      STEP_SUB_A1: begin
        w.acc_op = ACC_SUB_PROD;
        w.mul_op = MUL_A2;
      end
      STEP_SUB_A2: w.acc_op = ACC_SUB_PROD;
      STEP_MUL_G:  w.mul_op = MUL_G;
      STEP_WRITE: begin
        w.hist_wr = 1'b1;
        w.jmp     = JMP_SECTION;
      end
      STEP_FILT_END: w.jmp = JMP_FILTER;
      default: ;
    endcase
    return w;
  endfunction

endpackage

### rtl/core/dtbp_chan_if.sv
// ----------------------------------------------------------------------------
// dtbp_chan_if
// Valid/ready channel carrying one item of a given type.
// ----------------------------------------------------------------------------
interface dtbp_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/dtbp_biquad_dp.sv
// ----------------------------------------------------------------------------
// dtbp_biquad_dp
// Shared biquad datapath: one accumulator, one multiplier and the per-section
// input and accumulator histories of both filters.
// ----------------------------------------------------------------------------
module dtbp_biquad_dp #(
  parameter int SECTIONS   = 4,
  parameter int COEF_SHIFT = 10
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  dtbp_pkg::dp_ctrl_t                     ctrl,
  input  logic                                   idx_filt,
  input  logic [((SECTIONS > 1) ? $clog2(SECTIONS) : 1)-1:0] idx_sec,
  input  logic [11:0]                            sample,
  output logic signed [15:0]                     y_low16
);

  localparam int SEC_W      = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int HIST_DEPTH = 2 << SEC_W;

  localparam dtbp_pkg::coef_tbl_t G_TBL  =
    dtbp_pkg::coef_table(dtbp_pkg::COEF_G, COEF_SHIFT);
  localparam dtbp_pkg::coef_tbl_t A1_TBL =
    dtbp_pkg::coef_table(dtbp_pkg::COEF_A1, COEF_SHIFT);
  localparam dtbp_pkg::coef_tbl_t A2_TBL =
    dtbp_pkg::coef_table(dtbp_pkg::COEF_A2, COEF_SHIFT);

  localparam logic signed [32:0] Q_BIAS = 33'((longint'(1) <<< COEF_SHIFT) - 1);
  localparam logic signed [63:0] Y_BIAS = 64'((longint'(1) <<< (2 * COEF_SHIFT)) - 1);

  logic signed [31:0] x_r;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] prod_r, prod_nxt;
  logic signed [31:0] xh1_r [HIST_DEPTH];
  logic signed [31:0] xh2_r [HIST_DEPTH];
  logic signed [31:0] yh1_r [HIST_DEPTH];
  logic signed [31:0] yh2_r [HIST_DEPTH];

  logic [SEC_W:0]     hidx;
  logic [1:0]         row;
  logic signed [31:0] xh1, xh2, yh1, yh2;
  logic signed [31:0] b1_term, b2_term, x_term;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] mul_full;
  logic signed [63:0] y_wide;
  logic signed [31:0] y_val;

  // signed divide by one unit, truncating toward zero
  function automatic logic signed [31:0] div_one(input logic signed [31:0] v);
    logic signed [32:0] b;
    b = $signed({v[31], v}) + (v[31] ? Q_BIAS : 33'sd0);
    return 32'(b >>> COEF_SHIFT);
  endfunction

  assign hidx = {idx_filt, idx_sec};
  assign row  = 2'(idx_sec);

  assign xh1 = xh1_r[hidx];
  assign xh2 = xh2_r[hidx];
  assign yh1 = yh1_r[hidx];
  assign yh2 = yh2_r[hidx];

  // b1 is +2 units in rows 0 and 1, -2 units in rows 2 and 3
  always_comb begin
    b1_term = xh1 <<< (COEF_SHIFT + 1);
    if (row[1]) begin
      b1_term = -b1_term;
    end
    b2_term = xh2 <<< COEF_SHIFT;
    x_term  = x_r <<< COEF_SHIFT;
  end

  always_comb begin
    case (ctrl.mul_op)
      dtbp_pkg::MUL_A1: begin
        mul_a = $signed(A1_TBL[idx_filt][row]);
        mul_b = div_one(yh1);
      end
      dtbp_pkg::MUL_A2: begin
        mul_a = $signed(A2_TBL[idx_filt][row]);
        mul_b = div_one(yh2);
      end
      default: begin
        mul_a = $signed(G_TBL[idx_filt][row]);
        mul_b = acc_r;
      end
    endcase
  end

  // low 32 bits of the product, wrapped
  assign mul_full = mul_a * mul_b;

  always_comb begin
    prod_nxt = prod_r;
    if (ctrl.mul_op != dtbp_pkg::MUL_NONE) begin
      prod_nxt = mul_full;
    end
  end

  always_comb begin
    case (ctrl.acc_op)
      dtbp_pkg::ACC_LOAD_X:   acc_nxt = x_term;
      dtbp_pkg::ACC_ADD_B1:   acc_nxt = acc_r + b1_term;
      dtbp_pkg::ACC_ADD_B2:   acc_nxt = acc_r + b2_term;
      dtbp_pkg::ACC_SUB_PROD: acc_nxt = acc_r - prod_r;
      default:                acc_nxt = acc_r;
    endcase
  end

  // section output: g*Y divided by the square of one unit, truncating toward zero
  always_comb begin
    y_wide = 64'(prod_r);
    if (prod_r[31]) begin
      y_wide = y_wide + Y_BIAS;
    end
    y_val = 32'(y_wide >>> (2 * COEF_SHIFT));
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    if (ctrl.x_load) begin
      x_r <= 32'(sample);
    end else if (ctrl.hist_wr) begin
      x_r <= y_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        xh1_r[i] <= '0;
        xh2_r[i] <= '0;
        yh1_r[i] <= '0;
        yh2_r[i] <= '0;
      end
    end else if (ctrl.hist_wr) begin
      xh2_r[hidx] <= xh1;
      xh1_r[hidx] <= x_r;
      yh2_r[hidx] <= yh1;
      yh1_r[hidx] <= acc_r;
    end
  end

  assign y_low16 = x_r[15:0];

endmodule

### rtl/core/dual_tone_bandpass_peak_detector_core.sv
// ----------------------------------------------------------------------------
// dual_tone_bandpass_peak_detector_core
// Two biquad-cascade bandpass filters with windowed peak detection.
// ----------------------------------------------------------------------------
// Each accepted sample runs through the low-tone filter and then the
// high-tone filter on one shared multiply-accumulate datapath, driven by an
// eight-word microcode table: seven steps per biquad section plus one step
// to close each filter. No new sample is taken while one is in flight;
// the next is taken the cycle after the result is registered, even
// if that result has not yet been taken. The result carries both filter
// outputs cut to 16 bits, the held presence flags and a window_end marker
// on every WINDOW_LEN-th sample; the flags update on that sample. Threshold
// writes are taken at any time (cfg ready is always high) and should be
// made while no sample is in flight.
module dual_tone_bandpass_peak_detector_core #(
  parameter int SECTIONS   = 4,
  parameter int WINDOW_LEN = 16,
  parameter int COEF_SHIFT = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  dtbp_chan_if.sink    in_if,
  dtbp_chan_if.source  out_if,
  dtbp_chan_if.sink    cfg_if
);

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int WC_W  = $clog2(WINDOW_LEN);
  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);
  localparam logic [WC_W-1:0]  WC_LAST  = WC_W'(WINDOW_LEN - 1);

  dtbp_pkg::state_t    state_r, state_nxt;
  dtbp_pkg::step_t     step_r;
  logic [SEC_W-1:0]    sec_r;
  logic                filt_r;
  logic [11:0]         sample_r;
  logic signed [15:0]  lo_r, hi_r;
  logic signed [15:0]  peak_low_r, peak_high_r;
  logic [WC_W-1:0]     wcnt_r;
  logic [1:0]          flags_r;
  logic [14:0]         thr_low_r, thr_high_r;
  logic                out_valid_r;
  dtbp_pkg::out_item_t out_item_r;

  dtbp_pkg::uc_word_t  uc;
  dtbp_pkg::dp_ctrl_t  dp_ctrl;
  logic                in_accept;
  logic                out_push;
  logic                filt_done;
  logic [11:0]         load_sample;
  logic signed [15:0]  y_low16;
  logic signed [15:0]  peak_low_nxt, peak_high_nxt;
  logic                win_close;
  logic [1:0]          flags_nxt;

  // ---------------- sequencer ----------------
  assign in_accept = in_if.valid && in_if.ready;
  assign uc        = dtbp_pkg::ucode(step_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dtbp_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          state_nxt = dtbp_pkg::ST_RUN;
        end
      end
      dtbp_pkg::ST_RUN: begin
        if (uc.jmp == dtbp_pkg::JMP_FILTER && filt_r) begin
          state_nxt = dtbp_pkg::ST_DONE;
        end
      end
      dtbp_pkg::ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          state_nxt = dtbp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dtbp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = 1'b0;
    out_push    = 1'b0;
    filt_done   = 1'b0;
    dp_ctrl     = '{acc_op: dtbp_pkg::ACC_HOLD, mul_op: dtbp_pkg::MUL_NONE,
                    hist_wr: 1'b0, x_load: 1'b0};
    unique case (state_r)
      dtbp_pkg::ST_IDLE: begin
        in_if.ready    = 1'b1;
        dp_ctrl.x_load = in_if.valid;
      end
      dtbp_pkg::ST_RUN: begin
        dp_ctrl.acc_op  = uc.acc_op;
        dp_ctrl.mul_op  = uc.mul_op;
        dp_ctrl.hist_wr = uc.hist_wr;
        filt_done       = (uc.jmp == dtbp_pkg::JMP_FILTER);
        // second filter restarts from the raw sample
        dp_ctrl.x_load  = filt_done && !filt_r;
      end
      dtbp_pkg::ST_DONE: begin
        out_push = !out_valid_r || out_if.ready;
      end
      default: ;
    endcase
  end

  assign load_sample = (state_r == dtbp_pkg::ST_IDLE) ? in_if.payload.adc_sample : sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtbp_pkg::ST_IDLE;
      step_r  <= dtbp_pkg::STEP_LOAD;
      sec_r   <= '0;
      filt_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        step_r <= dtbp_pkg::STEP_LOAD;
        sec_r  <= '0;
        filt_r <= 1'b0;
      end else if (state_r == dtbp_pkg::ST_RUN) begin
        case (uc.jmp)
          dtbp_pkg::JMP_SECTION: begin
            if (sec_r == SEC_LAST) begin
              step_r <= dtbp_pkg::STEP_FILT_END;
            end else begin
              sec_r  <= sec_r + 1'b1;
              step_r <= dtbp_pkg::STEP_LOAD;
            end
          end
          dtbp_pkg::JMP_FILTER: begin
            filt_r <= 1'b1;
            sec_r  <= '0;
            step_r <= dtbp_pkg::STEP_LOAD;
          end
          default: step_r <= step_r + 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= in_if.payload.adc_sample;
    end
    if (filt_done) begin
      if (filt_r) begin
        hi_r <= y_low16;
      end else begin
        lo_r <= y_low16;
      end
    end
  end

  dtbp_biquad_dp #(
    .SECTIONS   (SECTIONS),
    .COEF_SHIFT (COEF_SHIFT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (dp_ctrl),
    .idx_filt (filt_r),
    .idx_sec  (sec_r),
    .sample   (load_sample),
    .y_low16  (y_low16)
  );

  // ---------------- peak tracking and window ----------------
  assign peak_low_nxt  = (lo_r > peak_low_r)  ? lo_r : peak_low_r;
  assign peak_high_nxt = (hi_r > peak_high_r) ? hi_r : peak_high_r;
  assign win_close     = (wcnt_r == WC_LAST);

  always_comb begin
    flags_nxt = flags_r;
    if (win_close) begin
      flags_nxt[0] = peak_low_nxt  > $signed({1'b0, thr_low_r});
      flags_nxt[1] = peak_high_nxt > $signed({1'b0, thr_high_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_low_r  <= '0;
      peak_high_r <= '0;
      wcnt_r      <= '0;
      flags_r     <= '0;
    end else if (out_push) begin
      flags_r <= flags_nxt;
      if (win_close) begin
        peak_low_r  <= '0;
        peak_high_r <= '0;
        wcnt_r      <= '0;
      end else begin
        peak_low_r  <= peak_low_nxt;
        peak_high_r <= peak_high_nxt;
        wcnt_r      <= wcnt_r + 1'b1;
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_push) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_item_r.filtered_low      <= lo_r;
      out_item_r.filtered_high     <= hi_r;
      out_item_r.low_tone_present  <= flags_nxt[0];
      out_item_r.high_tone_present <= flags_nxt[1];
      out_item_r.window_end        <= win_close;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_item_r;

  // ---------------- configuration ----------------
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_low_r  <= dtbp_pkg::THRESHOLD_RESET;
      thr_high_r <= dtbp_pkg::THRESHOLD_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.payload.index)
        dtbp_pkg::CFG_THRESHOLD_LOW:  thr_low_r  <= cfg_if.payload.data;
        dtbp_pkg::CFG_THRESHOLD_HIGH: thr_high_r <= cfg_if.payload.data;
        default: ;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == dtbp_pkg::ST_RUN && step_r == dtbp_pkg::STEP_LOAD &&
                   sec_r == '0 && !filt_r))
    else $error("sequencer did not restart at the first section of the low filter");

  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dtbp_pkg::ST_RUN |-> sec_r <= SEC_LAST)
    else $error("section counter beyond the last section");

  a_peaks_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !peak_low_r[15] && !peak_high_r[15])
    else $error("window peak went negative");

  a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && win_close) |=> (peak_low_r == '0 && peak_high_r == '0 && wcnt_r == '0))
    else $error("window close did not clear peaks and count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |=> $stable(out_item_r))
    else $error("pending result overwritten");

endmodule
